// ===== rtl/stack_machine_execute_top_defines.svh =====
// assertion macros for the stack machine execute block
`ifndef STACK_MACHINE_EXECUTE_TOP_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_TOP_DEFINES_SVH
// implication checked on every clock edge outside reset
`define SME_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define SME_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== rtl/sme_pkg.sv =====
//------------------------------------------------------------------------------
// sme_pkg
// types and opcode constants shared by the stack machine execute block
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package sme_pkg;
	typedef enum logic [3:0] {
		OP_LDC = 4'd0, OP_LD = 4'd1, OP_ST = 4'd2, OP_ADD = 4'd3,
		OP_SUB = 4'd4, OP_MUL = 4'd5, OP_DIV = 4'd6, OP_MOD = 4'd7,
		OP_CMP = 4'd8, OP_JMP = 4'd9, OP_BR = 4'd10, OP_HLT = 4'd11
	} opcode_t;

	typedef enum logic [1:0] {
		FAULT_NONE = 2'd0, FAULT_DIV0 = 2'd1, FAULT_UNDER = 2'd2, FAULT_OVER = 2'd3
	} fault_t;

	typedef struct packed {
		logic [3:0]         cmd;
		logic signed [31:0] immediate;
		logic [7:0]         mem_address;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] top_value;
		logic               redirect;
		logic               halted;
		logic [1:0]         fault;
	} result_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_WRITE, ST_FETCH, ST_DONE
	} state_t;
endpackage

// ===== rtl/sme_ram.sv =====
//------------------------------------------------------------------------------
// sme_ram
// generic single-port ram with registered read
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module sme_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

// ===== rtl/sme_front.sv =====
//------------------------------------------------------------------------------
// sme_front
// accepts commands into a two-entry queue
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module sme_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sme_pkg::cmd_t push_data,
	input  logic          pop,
	output logic          full,
	output logic          empty,
	output sme_pkg::cmd_t head
);
	sme_pkg::cmd_t slot_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head  = slot_q[rd_q];
	always_ff @(posedge clk) begin
		if (push && !full) slot_q[wr_q] <= push_data;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push && !full) wr_q <= ~wr_q;
			if (pop && !empty) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push && !full} - {1'b0, pop && !empty};
		end
	end
endmodule

// ===== rtl/sme_div.sv =====
//------------------------------------------------------------------------------
// sme_div
// iterative signed truncating divider, one quotient bit per cycle
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module sme_div #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0] q_q, r_q, d_q;
	logic nq_q, nr_q, busy_q;
	logic [CW-1:0] cnt_q;
	logic [W:0] trial;
	assign trial = {r_q, q_q[W-1]} - {1'b0, d_q};
	assign done = busy_q && cnt_q == CW'(0);
	assign quotient  = nq_q ? -q_q : q_q;
	assign remainder = nr_q ? -r_q : r_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1; cnt_q <= CW'(W);
		end else if (busy_q) begin
			if (cnt_q == CW'(0)) busy_q <= 1'b0;
			else cnt_q <= cnt_q - CW'(1);
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			q_q  <= dividend[W-1] ? -dividend : dividend;
			d_q  <= divisor[W-1] ? -divisor : divisor;
			r_q  <= '0;
			nq_q <= dividend[W-1] ^ divisor[W-1];
			nr_q <= dividend[W-1];
		end else if (busy_q && cnt_q != CW'(0)) begin
			if (!trial[W]) begin
				r_q <= trial[W-1:0];
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= {r_q[W-2:0], q_q[W-1]};
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end
endmodule

// ===== rtl/sme_back.sv =====
//------------------------------------------------------------------------------
// sme_back
// executes queued commands against the operand stack and data memory
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module sme_back #(
	parameter int STACK_DEPTH = 64,
	parameter int MEM_WORDS   = 256,
	parameter int DATA_WIDTH  = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  sme_pkg::cmd_t    head,
	output logic             pop,
	output logic             res_valid,
	output sme_pkg::result_t res
);
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int MAW = $clog2(MEM_WORDS);
	localparam int W   = DATA_WIDTH;

	sme_pkg::state_t state_q, state_d;
	logic [SPW-1:0] sp_q;
	logic halt_q;
	logic [MAW-1:0] clr_q;
	sme_pkg::cmd_t cur_q;
	logic [W-1:0] top_q, nxt_q, res_word_q;
	logic rd_phase_q;

	// stack ram
	logic s_we; logic [SAW-1:0] s_addr; logic [W-1:0] s_wdata, s_rdata;
	sme_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata));
	// data ram
	logic m_we; logic [MAW-1:0] m_addr; logic [W-1:0] m_wdata, m_rdata;
	sme_ram #(.WIDTH(W), .DEPTH(MEM_WORDS)) u_mem (
		.clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata));

	// next-top arrives on the stack read port in the exec state
	logic dv_start, dv_done; logic [W-1:0] dv_q, dv_r;
	sme_div #(.W(W)) u_div (.clk(clk), .arst_n(arst_n), .start(dv_start),
		.dividend(s_rdata), .divisor(top_q), .done(dv_done),
		.quotient(dv_q), .remainder(dv_r));

	logic [3:0] op;
	assign op = cur_q.cmd;
	logic need2, need1, push1;
	assign need2 = op inside {sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL,
		sme_pkg::OP_DIV, sme_pkg::OP_MOD, sme_pkg::OP_CMP};
	assign need1 = op inside {sme_pkg::OP_ST, sme_pkg::OP_BR, sme_pkg::OP_HLT};
	assign push1 = op inside {sme_pkg::OP_LDC, sme_pkg::OP_LD};
	logic under, over, div0;
	assign under = (need2 && sp_q < SPW'(2)) || (need1 && sp_q == SPW'(0));
	assign over  = push1 && sp_q == SPW'(STACK_DEPTH);
	assign div0  = (op == sme_pkg::OP_DIV || op == sme_pkg::OP_MOD) && top_q == '0;

	logic [W-1:0] alu, imm_x;
	assign imm_x = W'($signed(cur_q.immediate));
	always_comb begin
		case (op)
			sme_pkg::OP_ADD: alu = nxt_q + top_q;
			sme_pkg::OP_SUB: alu = nxt_q - top_q;
			sme_pkg::OP_CMP: alu = ($signed(nxt_q) < $signed(top_q)) ? '1 :
				(nxt_q == top_q) ? '0 : W'(1);
			default:         alu = '0;
		endcase
	end

	// value written to the stack in the write state
	logic [W-1:0] wval;
	always_comb begin
		case (op)
			sme_pkg::OP_LD:  wval = m_rdata;
			sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_CMP: wval = alu;
			default:         wval = res_word_q;
		endcase
	end

	logic [SPW-1:0] sp_next;
	always_comb begin
		sp_next = sp_q;
		if (!under && !over && !div0) begin
			if (push1) sp_next = sp_q + SPW'(1);
			else if (need1 || need2) sp_next = sp_q - SPW'(1);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sme_pkg::ST_CLEAR: if (clr_q == MAW'(MEM_WORDS - 1)) state_d = sme_pkg::ST_IDLE;
			sme_pkg::ST_IDLE:  if (!empty) state_d = sme_pkg::ST_READ;
			sme_pkg::ST_READ:  state_d = rd_phase_q ? sme_pkg::ST_EXEC : sme_pkg::ST_READ;
			sme_pkg::ST_EXEC: begin
				if (halt_q || under || over || div0) state_d = sme_pkg::ST_FETCH;
				else if (op == sme_pkg::OP_DIV || op == sme_pkg::OP_MOD)
					state_d = sme_pkg::ST_DIV;
				else state_d = sme_pkg::ST_WRITE;
			end
			sme_pkg::ST_DIV:   if (dv_done) state_d = sme_pkg::ST_WRITE;
			sme_pkg::ST_WRITE: state_d = sme_pkg::ST_FETCH;
			sme_pkg::ST_FETCH: state_d = sme_pkg::ST_DONE;
			sme_pkg::ST_DONE:  state_d = sme_pkg::ST_IDLE;
			default:           state_d = sme_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_we = 1'b0; s_addr = '0; s_wdata = wval;
		m_we = 1'b0; m_addr = MAW'(cur_q.mem_address); m_wdata = top_q;
		pop = 1'b0; dv_start = 1'b0;
		case (state_q)
			sme_pkg::ST_CLEAR: begin m_we = 1'b1; m_addr = clr_q; m_wdata = '0; end
			sme_pkg::ST_IDLE:  pop = !empty;
			sme_pkg::ST_READ:  s_addr = rd_phase_q ? SAW'(sp_q - SPW'(2)) : SAW'(sp_q - SPW'(1));
			sme_pkg::ST_EXEC:  dv_start = !halt_q && !under && !div0 &&
				(op == sme_pkg::OP_DIV || op == sme_pkg::OP_MOD);
			sme_pkg::ST_WRITE: begin
				if (op == sme_pkg::OP_ST) m_we = 1'b1;
				else if (push1 || need2) begin
					s_we = 1'b1;
					s_addr = SAW'(sp_next - SPW'(1));
				end
			end
			sme_pkg::ST_FETCH: s_addr = SAW'(sp_q - SPW'(1));
			default: ;
		endcase
	end

	logic [1:0] fault_q; logic redir_q, rep_q; logic [W-1:0] rep_word_q;
	assign res_valid = state_q == sme_pkg::ST_DONE;
	always_comb begin
		res.top_value = rep_q ? 32'($signed(rep_word_q)) :
			(sp_q == SPW'(0) ? 32'sd0 : 32'($signed(s_rdata)));
		res.redirect = redir_q;
		res.halted   = halt_q;
		res.fault    = fault_q;
	end

	always_ff @(posedge clk) begin
		if (state_q == sme_pkg::ST_READ) begin
			if (rd_phase_q) top_q <= s_rdata; // first address data arrives now
		end
		if (state_q == sme_pkg::ST_EXEC) nxt_q <= s_rdata;
		if (state_q == sme_pkg::ST_IDLE) cur_q <= head;
	end

	// result word from the immediate, the product or the divider
	always_ff @(posedge clk) begin
		case (state_q)
			sme_pkg::ST_EXEC: begin
				case (op)
					sme_pkg::OP_LDC: res_word_q <= imm_x;
					sme_pkg::OP_MUL: res_word_q <= W'(s_rdata * top_q);
					default:         res_word_q <= '0;
				endcase
			end
			sme_pkg::ST_DIV: if (dv_done) res_word_q <= (op == sme_pkg::OP_DIV) ? dv_q : dv_r;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sme_pkg::ST_CLEAR; sp_q <= '0; halt_q <= 1'b0; clr_q <= '0;
			rd_phase_q <= 1'b0; fault_q <= '0; redir_q <= 1'b0; rep_q <= 1'b0;
			rep_word_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == sme_pkg::ST_CLEAR) clr_q <= clr_q + MAW'(1);
			if (state_q == sme_pkg::ST_READ) rd_phase_q <= ~rd_phase_q;
			if (state_q == sme_pkg::ST_EXEC) begin
				rep_q <= 1'b0; redir_q <= 1'b0;
				fault_q <= sme_pkg::FAULT_NONE;
				if (!halt_q) begin
					if (under) fault_q <= sme_pkg::FAULT_UNDER;
					else if (over) fault_q <= sme_pkg::FAULT_OVER;
					else if (div0) fault_q <= sme_pkg::FAULT_DIV0;
					if (op == sme_pkg::OP_JMP) redir_q <= 1'b1;
					if (op == sme_pkg::OP_BR && !under) redir_q <= top_q != '0;
					if (op == sme_pkg::OP_HLT) begin
						halt_q <= 1'b1; rep_q <= 1'b1;
						rep_word_q <= under ? '0 : top_q;
					end
					// pushes and two-operand results move the pointer at the write
					if (under || over || div0 || !(push1 || need2)) sp_q <= sp_next;
				end
			end
			if (state_q == sme_pkg::ST_WRITE && (push1 || need2)) sp_q <= sp_next;
		end
	end
endmodule

// ===== rtl/stack_machine_execute_top.sv =====
// sequence: a command passes IDLE, READ (top, then next-top), EXEC, WRITE, FETCH
// and DONE, which raises the result strobe; a fault or a halted block skips WRITE,
// and div and mod otherwise wait in DIV on the iterative divider before WRITE
// (one quotient bit per cycle); flow: the executor runs one command at a time; the
// two-entry queue takes transfers while the executor works, busy when full
// reset: after arst_n the data memory is cleared one word a cycle; no command runs in the clear cycles
//------------------------------------------------------------------------------
// stack_machine_execute_top
// stack machine execute block: front queue and back executor
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module stack_machine_execute_top #(
	parameter int STACK_DEPTH = 64,
	parameter int MEM_WORDS   = 256,
	parameter int DATA_WIDTH  = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  sme_pkg::cmd_t    cmd,
	output logic             strobe,
	output sme_pkg::result_t result
);
	logic pop, full, empty;
	sme_pkg::cmd_t head;
	// front side: queue takes a transfer whenever a slot is free
	assign busy = full;
	sme_front u_front (.clk(clk), .arst_n(arst_n), .push(start), .push_data(cmd),
		.pop(pop), .full(full), .empty(empty), .head(head));
	// back side: one command at a time, result strobed for one cycle
	sme_back #(.STACK_DEPTH(STACK_DEPTH), .MEM_WORDS(MEM_WORDS),
		.DATA_WIDTH(DATA_WIDTH)) u_back (.clk(clk), .arst_n(arst_n),
		.empty(empty), .head(head), .pop(pop),
		.res_valid(strobe), .res(result));
endmodule

// ===== rtl/sme_checker.sv =====
//------------------------------------------------------------------------------
// sme_checker
// port-level checks for the execute block
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stack_machine_execute_top_defines.svh"
module sme_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             strobe,
	input sme_pkg::result_t result
);
	// a strobe that directly follows a halted strobe must also be halted
	`SME_ASSERT_NEXT(a_halt_sticky, strobe && result.halted, !strobe || result.halted)
	// strobes are single cycle
	`SME_ASSERT_NEXT(a_strobe_pulse, strobe, !strobe)
	// an underflow-faulted result never redirects
	`SME_ASSERT_IMPL(a_fault_redir, strobe && result.fault == sme_pkg::FAULT_UNDER,
		!result.redirect)
endmodule

bind stack_machine_execute_top sme_checker u_chk (.clk(clk), .arst_n(arst_n),
	.strobe(strobe), .result(result));

// ===== tb/sv/tb_stack_machine_execute_top.sv =====
//------------------------------------------------------------------------------
// tb_stack_machine_execute_top
// self-checking bench: drives decoded stack-machine commands, predicts each
// result with a behavioral model of the stack and data memory, and compares
// every strobed result field by field in order
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

// scoreboard: predicts results of accepted commands and checks strobed ones
class sme_scoreboard;
	logic [31:0] stack_words[64];
	int unsigned depth;
	logic [31:0] mem_words[256];
	bit halt_seen;
	sme_pkg::result_t pending[$];
	int unsigned errors;
	int unsigned checked;

	function void clear_state();
		depth = 0;
		halt_seen = 0;
		foreach (mem_words[i]) mem_words[i] = '0;
		foreach (stack_words[i]) stack_words[i] = '0;
		pending.delete();
	endfunction

	function logic [31:0] top_word();
		return (depth == 0) ? 32'd0 : stack_words[depth - 1];
	endfunction

	// apply one accepted command to the model and queue the expected result
	function void note_transfer(sme_pkg::cmd_t c);
		sme_pkg::result_t r;
		logic signed [31:0] t, n, q;
		bit use_report;
		logic [31:0] report;
		r = '0;
		use_report = 0;
		report = '0;
		if (halt_seen) begin
			r.top_value = top_word();
			r.halted = 1'b1;
			pending.push_back(r);
			return;
		end
		case (c.cmd)
			sme_pkg::OP_LDC, sme_pkg::OP_LD: begin
				if (depth >= 64) r.fault = sme_pkg::FAULT_OVER;
				else begin
					stack_words[depth] = (c.cmd == sme_pkg::OP_LDC) ? c.immediate
						: mem_words[c.mem_address];
					depth++;
				end
			end
			sme_pkg::OP_ST: begin
				if (depth < 1) r.fault = sme_pkg::FAULT_UNDER;
				else begin
					mem_words[c.mem_address] = stack_words[depth - 1];
					depth--;
				end
			end
			sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
			sme_pkg::OP_MOD, sme_pkg::OP_CMP: begin
				if (depth < 2) r.fault = sme_pkg::FAULT_UNDER;
				else begin
					t = stack_words[depth - 1];
					n = stack_words[depth - 2];
					if ((c.cmd == sme_pkg::OP_DIV || c.cmd == sme_pkg::OP_MOD) && t == 0)
						r.fault = sme_pkg::FAULT_DIV0;
					else begin
						case (c.cmd)
							sme_pkg::OP_ADD: q = n + t;
							sme_pkg::OP_SUB: q = n - t;
							sme_pkg::OP_MUL: q = n * t;
							// most negative over -1 wraps to itself
							sme_pkg::OP_DIV: q = (t == -1) ? -n : n / t;
							sme_pkg::OP_MOD: q = (t == -1) ? 32'sd0 : n % t;
							default: q = (n < t) ? -32'sd1 : ((n == t) ? 32'sd0 : 32'sd1);
						endcase
						stack_words[depth - 2] = q;
						depth--;
					end
				end
			end
			sme_pkg::OP_JMP: r.redirect = 1'b1;
			sme_pkg::OP_BR: begin
				if (depth < 1) r.fault = sme_pkg::FAULT_UNDER;
				else begin
					r.redirect = (stack_words[depth - 1] != 0);
					depth--;
				end
			end
			sme_pkg::OP_HLT: begin
				halt_seen = 1;
				use_report = 1;
				if (depth < 1) r.fault = sme_pkg::FAULT_UNDER;
				else begin
					report = stack_words[depth - 1];
					depth--;
				end
			end
			default: ;
		endcase
		r.top_value = use_report ? report : top_word();
		r.halted = halt_seen;
		pending.push_back(r);
	endfunction

	function void check_result(sme_pkg::result_t got);
		sme_pkg::result_t want;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result %h", $time, got);
			errors++;
			return;
		end
		want = pending.pop_front();
		checked++;
		if (got.top_value !== want.top_value) begin
			$display("%0t: top_value expected %0d actual %0d", $time, want.top_value,
				got.top_value);
			errors++;
		end
		if (got.redirect !== want.redirect) begin
			$display("%0t: redirect expected %b actual %b", $time, want.redirect,
				got.redirect);
			errors++;
		end
		if (got.halted !== want.halted) begin
			$display("%0t: halted expected %b actual %b", $time, want.halted, got.halted);
			errors++;
		end
		if (got.fault !== want.fault) begin
			$display("%0t: fault expected %0d actual %0d", $time, want.fault, got.fault);
			errors++;
		end
	endfunction
endclass

module tb_stack_machine_execute_top;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 60;
	localparam logic [3:0] UNUSED_OPCODE = 4'd15;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	sme_pkg::cmd_t cmd = '0;
	logic strobe;
	sme_pkg::result_t result;

	sme_scoreboard board;
	int unsigned idle_cycles;
	int unsigned sent;
	int unsigned burst_left;
	bit timed_out;

	stack_machine_execute_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .strobe(strobe), .result(result)
	);

	always #1 clk = ~clk;

	// results are single-cycle strobes, checked at the edge that ends them
	always @(posedge clk) begin
		if (arst_n && strobe) board.check_result(result);
	end

	// watchdog: counts cycles in which neither side transfers anything
	always @(posedge clk) begin
		if (!arst_n || strobe || (start && !busy)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("stack_machine_execute_top verification failed");
			$finish;
		end
	end

	// present one command and hold it until the transfer; the sender may idle
	// between bursts of random length, start stays high inside a burst
	task automatic issue(input sme_pkg::cmd_t c);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		board.note_transfer(c);
		sent++;
	endtask

	task automatic op(input sme_pkg::opcode_t o, input logic [31:0] imm = '0,
		input logic [7:0] a = '0);
		sme_pkg::cmd_t c;
		c.cmd = o;
		c.immediate = imm;
		c.mem_address = a;
		issue(c);
	endtask

	// stop sending and wait for every expected result
	task automatic drain();
		start <= 1'b0;
		burst_left = 0;
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	// random operand value weighted toward edges
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'd0;
			4: return $urandom_range(0, 20) - 10;
			default: return $urandom;
		endcase
	endfunction

	// one random command with a mostly well-formed operand mix
	task automatic random_item();
		sme_pkg::cmd_t c;
		int sel;
		c.immediate = pick_value();
		c.mem_address = 8'($urandom);
		sel = $urandom_range(0, 99);
		if (board.depth < 2 && sel < 70) c.cmd = (sel < 50) ? sme_pkg::OP_LDC : sme_pkg::OP_LD;
		else if (board.depth > 56 && sel < 60) c.cmd = 4'(sme_pkg::OP_ST + $urandom_range(0, 6));
		else if (sel < 97) c.cmd = 4'($urandom_range(0, 10));
		else c.cmd = 4'($urandom_range(12, 15));
		issue(c);
	endtask

	initial begin
		sme_pkg::cmd_t nop_c;
		board = new();
		board.clear_state();
		board.errors = 0;
		board.checked = 0;
		idle_cycles = 0;
		sent = 0;
		burst_left = 0;
		timed_out = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: underflow on empty stack, extremes, every opcode but halt
		op(sme_pkg::OP_ADD);
		op(sme_pkg::OP_ST, 0, 8'hff);
		op(sme_pkg::OP_BR);
		op(sme_pkg::OP_LD, 0, 8'hff);
		op(sme_pkg::OP_LDC, 32'h8000_0000);
		op(sme_pkg::OP_LDC, 32'hffff_ffff);
		op(sme_pkg::OP_DIV);
		op(sme_pkg::OP_LDC, 32'h8000_0000);
		op(sme_pkg::OP_LDC, 32'hffff_ffff);
		op(sme_pkg::OP_MOD);
		op(sme_pkg::OP_LDC, 0);
		op(sme_pkg::OP_DIV);
		op(sme_pkg::OP_MOD);
		op(sme_pkg::OP_LDC, 32'h7fff_ffff);
		op(sme_pkg::OP_LDC, 32'h7fff_ffff);
		op(sme_pkg::OP_MUL);
		op(sme_pkg::OP_LDC, 5);
		op(sme_pkg::OP_SUB);
		op(sme_pkg::OP_LDC, 3);
		op(sme_pkg::OP_CMP);
		op(sme_pkg::OP_ST, 0, 8'hff);
		op(sme_pkg::OP_JMP);
		op(sme_pkg::OP_BR);
		op(sme_pkg::OP_LDC, 1);
		op(sme_pkg::OP_BR);
		// fill to overflow, then empty by stores
		for (int i = 0; i < 66; i++) op(sme_pkg::OP_LDC, $urandom);
		for (int i = 0; i < 66; i++) op(sme_pkg::OP_ST, 0, 8'($urandom));
		nop_c.cmd = UNUSED_OPCODE;
		nop_c.immediate = 32'h5a5a_a5a5;
		nop_c.mem_address = 8'h00;
		issue(nop_c);

		// hold off until the block has drained completely
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		for (int i = 0; i < 1240; i++) random_item();

		// halt on a loaded stack, then items that must be ignored
		op(sme_pkg::OP_LDC, 32'h1234_5678);
		op(sme_pkg::OP_HLT);
		for (int i = 0; i < 10; i++) random_item();
		op(sme_pkg::OP_HLT);

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run covered %0d commands and %0d checked results,", sent, board.checked);
		$display("including stack limits, divide corner cases, branches and halt");
		if (board.errors == 0 && board.pending.size() == 0)
			$display("stack_machine_execute_top verification clean");
		else
			$display("stack_machine_execute_top verification failed");
		$finish;
	end
endmodule
